/* rtl/ocp_pkg.sv */
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared types and constants of the oven countdown and power controller:
// keypad codes, register indexes, reset values and the item, state and
// result records passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ocp_pkg;

  // Keypad scan codes with a fixed meaning
  localparam logic [7:0] CODE_START  = 8'h18;
  localparam logic [7:0] CODE_SWITCH = 8'h08;
  localparam logic [7:0] CODE_POWER  = 8'h10;
  localparam logic [7:0] CODE_NONE   = 8'hFF;

  // Digit keys, in the order of the digit they stand for
  localparam logic [7:0] CODE_DIGIT0 = 8'h00;
  localparam logic [7:0] CODE_DIGIT1 = 8'h01;
  localparam logic [7:0] CODE_DIGIT2 = 8'h09;
  localparam logic [7:0] CODE_DIGIT3 = 8'h11;
  localparam logic [7:0] CODE_DIGIT4 = 8'h02;
  localparam logic [7:0] CODE_DIGIT5 = 8'h0A;
  localparam logic [7:0] CODE_DIGIT6 = 8'h12;
  localparam logic [7:0] CODE_DIGIT7 = 8'h03;
  localparam logic [7:0] CODE_DIGIT8 = 8'h0B;
  localparam logic [7:0] CODE_DIGIT9 = 8'h13;

  // Selection codes
  localparam logic [2:0] SEL_SEC_ONES = 3'd1;
  localparam logic [2:0] SEL_MIN_TENS = 3'd4;
  localparam logic [2:0] SEL_POWER    = 3'd5;

  // Configuration register indexes
  localparam int unsigned    CFG_INDEX_W     = 1;
  localparam int unsigned    CFG_DATA_W      = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_PERIOD     = 1'd1;

  // Reset values
  localparam logic [7:0] TICKS_PER_SECOND_RESET = 8'd20;
  localparam logic [3:0] POWER_PERIOD_RESET     = 4'd10;
  localparam logic [3:0] POWER_RESET            = 4'd3;

  // Beep counts
  localparam logic [3:0] BEEPS_KEY        = 4'd1;
  localparam logic [3:0] BEEPS_DOOR_WARN  = 4'd4;
  localparam logic [3:0] BEEPS_STOP       = 4'd5;
  localparam logic [3:0] BEEPS_MAX        = 4'd5;

  // Port widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef struct packed {
    logic       action;
    logic [7:0] key_code;
    logic       door_open;
  } item_t;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [3:0] power_period;
  } cfg_t;

  // digits[0] second units, [1] second tens, [2] minute units, [3] minute tens
  typedef struct packed {
    logic            run_flag;
    logic [3:0][3:0] digits;
    logic [2:0]      selected;
    logic [3:0]      power;
    logic [7:0]      tick_count;
    logic [3:0]      second_in_period;
    logic            heater;
  } state_t;

  typedef struct packed {
    logic       door_lamp;
    logic [2:0] beep_count;
    logic [2:0] selected_field;
    logic [3:0] power_level;
    logic [3:0] second_ones;
    logic [3:0] second_tens;
    logic [3:0] minute_ones;
    logic [3:0] minute_tens;
    logic       running;
    logic       heater_on;
  } result_t;

  // Handshake status between the input register and the result side
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage

`default_nettype wire

/* rtl/oven_countdown_power_controller_unit.sv */
// ----------------------------------------------------------------------------
// oven_countdown_power_controller_unit
// Heating-appliance controller: keypad time and power entry, mm:ss
// countdown on timer ticks, time-proportional heater drive and beeps.
//
//   channel   direction  signals                       contents
//   s_axis    in         s_tvalid s_tready s_tdata     key_code, door_open
//                        s_tuser                       action
//   m_axis    out        m_tvalid m_tready m_tdata     one result per item
//   cfg       in         cfg_we cfg_index cfg_data     ticks_per_second,
//                                                      power_period
//
// Each item passes from the input register, where the step logic works on
// it, into the result register; a stalled m_tready can hold it in between.
// A new item is taken in every cycle while the result side has room; the
// step logic and state register form a loop that sustains one item per cycle.
// Reset is synchronous: state returns to idle, 00:00, power 3, selection 1.
// A stalled m_tready holds the result; the input register still takes one
// more item and then s_tready follows m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module oven_countdown_power_controller_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // s_tdata: key_code [7:0], door_open [8], zero [15:9]
  input  wire logic [ocp_pkg::IN_TDATA_W-1:0]      s_tdata,
  // s_tuser: action [0]
  input  wire logic                                s_tuser,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // m_tdata: heater_on [0], running [1], minute_tens [5:2], minute_ones [9:6],
  // second_tens [13:10], second_ones [17:14], power_level [21:18],
  // selected_field [24:22], beep_count [27:25], door_lamp [28], zero [31:29]
  output logic [ocp_pkg::OUT_TDATA_W-1:0]          m_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_we,
  input  wire logic [ocp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [ocp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  ocp_pkg::item_t      item_in;
  ocp_pkg::item_t      item;
  ocp_pkg::stage_ctl_t ctl;
  ocp_pkg::state_t     st;
  ocp_pkg::state_t     st_next;
  ocp_pkg::cfg_t       cfg;
  ocp_pkg::result_t    res;
  ocp_pkg::result_t    res_q;
  logic                advance;
  logic                fire;

  // Unpack the input transfer
  assign item_in.action    = s_tuser;
  assign item_in.key_code  = s_tdata[7:0];
  assign item_in.door_open = s_tdata[8];

  // The result register can take a new result when empty or being emptied.
  assign advance = !m_tvalid || m_tready;
  assign fire    = ctl.valid && ctl.advance;

  ocp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .item_in  (item_in),
    .advance  (advance),
    .ctl      (ctl),
    .item     (item)
  );

  ocp_step u_step (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_second <= ocp_pkg::TICKS_PER_SECOND_RESET;
      cfg.power_period     <= ocp_pkg::POWER_PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ocp_pkg::REG_TICKS_PER_SECOND: cfg.ticks_per_second <= cfg_data;
        ocp_pkg::REG_POWER_PERIOD:     cfg.power_period     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Controller state, updated once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      st.run_flag         <= 1'b0;
      st.digits           <= '0;
      st.selected         <= ocp_pkg::SEL_SEC_ONES;
      st.power            <= ocp_pkg::POWER_RESET;
      st.tick_count       <= 8'd0;
      st.second_in_period <= 4'd0;
      st.heater           <= 1'b0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= res;
    end
  end

  // Pack the result transfer, last field (heater_on) lowest
  assign m_tdata = {3'd0, res_q.door_lamp, res_q.beep_count, res_q.selected_field,
                    res_q.power_level, res_q.second_ones, res_q.second_tens,
                    res_q.minute_ones, res_q.minute_tens, res_q.running,
                    res_q.heater_on};

  // A stored item always moves on when the result side has room.
  a_fire_loads: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("item in input register did not produce a result");

  // The heater is never reported on outside a run.
  a_heater_running: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!res_q.heater_on || res_q.running))
    else $error("heater on while not running");

  // Beep requests saturate at five.
  a_beep_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res_q.beep_count <= ocp_pkg::BEEPS_MAX[2:0]))
    else $error("beep count above limit");

  // A run never rests at 00:00; it stops in the same step.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.run_flag |-> (st.digits != '0))
    else $error("running with zero time");

  // Selection stays within its five codes.
  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    (st.selected >= ocp_pkg::SEL_SEC_ONES) && (st.selected <= ocp_pkg::SEL_POWER))
    else $error("selection out of range");

endmodule

`default_nettype wire

/* rtl/ocp_in_reg.sv */
// ----------------------------------------------------------------------------
// ocp_in_reg
// Input register: takes one item per transfer and holds it until the
// result side has room for its result.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_in_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire ocp_pkg::item_t    item_in,
  input  wire logic              advance,
  output ocp_pkg::stage_ctl_t    ctl,
  output ocp_pkg::item_t         item
);

  logic valid;

  // The register may refill in the cycle that it hands its item on.
  assign s_tready    = !valid || advance;
  assign ctl.valid   = valid;
  assign ctl.advance = advance;

  // Occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  // Held item
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_in;
    end
  end

endmodule

`default_nettype wire

/* rtl/ocp_step.sv */
// ----------------------------------------------------------------------------
// ocp_step
// Next-state and result logic for one item: keypad editing, start, the
// per-second countdown, heater duty cycle and the stop sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module ocp_step (
  input  wire ocp_pkg::item_t   item,
  input  wire ocp_pkg::state_t  st,
  input  wire ocp_pkg::cfg_t    cfg,
  output ocp_pkg::state_t       st_next,
  output ocp_pkg::result_t      res
);

  // Decode a digit key into its value; valid is low for any other code.
  function automatic logic [4:0] decode_digit(input logic [7:0] code);
    logic [4:0] r;
    r = 5'd0;
    case (code)
      ocp_pkg::CODE_DIGIT0: r = {1'b1, 4'd0};
      ocp_pkg::CODE_DIGIT1: r = {1'b1, 4'd1};
      ocp_pkg::CODE_DIGIT2: r = {1'b1, 4'd2};
      ocp_pkg::CODE_DIGIT3: r = {1'b1, 4'd3};
      ocp_pkg::CODE_DIGIT4: r = {1'b1, 4'd4};
      ocp_pkg::CODE_DIGIT5: r = {1'b1, 4'd5};
      ocp_pkg::CODE_DIGIT6: r = {1'b1, 4'd6};
      ocp_pkg::CODE_DIGIT7: r = {1'b1, 4'd7};
      ocp_pkg::CODE_DIGIT8: r = {1'b1, 4'd8};
      ocp_pkg::CODE_DIGIT9: r = {1'b1, 4'd9};
      default:              r = 5'd0;
    endcase
    return r;
  endfunction

  // One-second BCD countdown of mm:ss with borrows.
  function automatic logic [3:0][3:0] count_down(input logic [3:0][3:0] d);
    logic [3:0][3:0] r;
    r = d;
    if (d[0] != 4'd0) begin
      r[0] = d[0] - 4'd1;
    end else begin
      r[0] = 4'd9;
      if (d[1] != 4'd0) begin
        r[1] = d[1] - 4'd1;
      end else begin
        r[1] = 4'd5;
        if (d[2] != 4'd0) begin
          r[2] = d[2] - 4'd1;
        end else begin
          r[2] = 4'd9;
          if (d[3] != 4'd0) begin
            r[3] = d[3] - 4'd1;
          end
        end
      end
    end
    return r;
  endfunction

  logic [4:0] digit;
  logic [2:0] sel_m1;
  logic [7:0] tick_inc;
  logic [3:0] sip_inc;
  logic [3:0] sip_new;
  logic [3:0] beeps;
  logic [3:0] beeps_sat;
  logic       stop;

  assign digit    = decode_digit(item.key_code);
  assign sel_m1   = st.selected - 3'd1;
  assign tick_inc = st.tick_count + 8'd1;
  assign sip_inc  = st.second_in_period + 4'd1;
  assign sip_new  = (sip_inc >= cfg.power_period) ? 4'd0 : sip_inc;

  // Item handling
  always_comb begin
    st_next = st;
    beeps   = 4'd0;
    stop    = 1'b0;
    if (st.run_flag) begin
      // Running: the door is tested first, keys are ignored.
      if (item.door_open) begin
        stop = 1'b1;
      end else if (!item.action) begin
        if (tick_inc < cfg.ticks_per_second) begin
          st_next.tick_count = tick_inc;
        end else begin
          st_next.tick_count       = 8'd0;
          st_next.second_in_period = sip_new;
          st_next.heater           = (sip_new < st.power);
          st_next.digits           = count_down(st.digits);
          if (count_down(st.digits) == '0) begin
            stop = 1'b1;
          end
        end
      end
    end else if (item.action && (item.key_code != ocp_pkg::CODE_NONE)) begin
      // Idle key: one beep (four for start with the door open), then the key's own action.
      beeps = ocp_pkg::BEEPS_KEY;
      case (item.key_code)
        ocp_pkg::CODE_START: begin
          if (item.door_open) begin
            beeps = ocp_pkg::BEEPS_DOOR_WARN;
          end else begin
            st_next.run_flag         = 1'b1;
            st_next.selected         = ocp_pkg::SEL_POWER;
            st_next.tick_count       = 8'd0;
            st_next.second_in_period = 4'd0;
            st_next.heater           = (st.power != 4'd0);
            if (st.digits == '0) begin
              stop = 1'b1;
            end
          end
        end
        ocp_pkg::CODE_SWITCH: begin
          st_next.selected = (st.selected >= ocp_pkg::SEL_MIN_TENS) ?
                             ocp_pkg::SEL_SEC_ONES : st.selected + 3'd1;
        end
        ocp_pkg::CODE_POWER: begin
          st_next.selected = ocp_pkg::SEL_POWER;
        end
        default: begin
          if (digit[4]) begin
            if (st.selected == ocp_pkg::SEL_POWER) begin
              st_next.power = digit[3:0];
            end else if ((st.selected >= ocp_pkg::SEL_SEC_ONES) &&
                         (st.selected <= ocp_pkg::SEL_MIN_TENS)) begin
              st_next.digits[sel_m1[1:0]] = digit[3:0];
            end
          end
        end
      endcase
    end

    // Stop: back to idle with the settings as after reset.
    if (stop) begin
      st_next.run_flag = 1'b0;
      st_next.heater   = 1'b0;
      st_next.digits   = '0;
      st_next.selected = ocp_pkg::SEL_SEC_ONES;
      st_next.power    = ocp_pkg::POWER_RESET;
      beeps            = beeps + ocp_pkg::BEEPS_STOP;
    end
  end

  assign beeps_sat = (beeps > ocp_pkg::BEEPS_MAX) ? ocp_pkg::BEEPS_MAX : beeps;

  // Result fields from the updated state
  always_comb begin
    res.heater_on      = st_next.run_flag & st_next.heater;
    res.running        = st_next.run_flag;
    res.minute_tens    = st_next.digits[3];
    res.minute_ones    = st_next.digits[2];
    res.second_tens    = st_next.digits[1];
    res.second_ones    = st_next.digits[0];
    res.power_level    = st_next.power;
    res.selected_field = st_next.selected;
    res.beep_count     = beeps_sat[2:0];
    res.door_lamp      = item.door_open;
  end

endmodule

`default_nettype wire
